@@ rtl/weighted_force_filter_offset_defines.svh @@
// ----------------------------------------------------------------------------
// Weighted force filter assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_FORCE_FILTER_OFFSET_DEFINES_SVH
`define WEIGHTED_FORCE_FILTER_OFFSET_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define WFFO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The consequent starts in the same cycle as the antecedent.
`define WFFO_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/wffo_pkg.sv @@
// ----------------------------------------------------------------------------
// Weighted force filter package
// Widths, filter coefficients, sequencer states and shared helpers.
// ----------------------------------------------------------------------------
package wffo_pkg;

	localparam int DATA_W = 32;
	localparam int CFG_W  = 20;
	localparam int COEF_W = 16;
	localparam int PROD_W = DATA_W + COEF_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int ROUND_SHIFT = 15;

	// Q1.15 coefficients.
	localparam logic signed [COEF_W-1:0] COEF_HALF  = 16'sd16384;
	localparam logic signed [COEF_W-1:0] COEF_FIFTH = 16'sd6554;
	localparam logic signed [COEF_W-1:0] COEF_TENTH = 16'sd3277;

	localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(16384);

	localparam logic [CFG_W-1:0] CAPTURE_RESET = 20'd1000;
	localparam logic [CFG_W-1:0] SEEN_MAX      = '1;

	localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_FIN,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		TAP_X,
		TAP_Y1,
		TAP_Y2,
		TAP_Y3
	} tap_t;

	typedef struct packed {
		logic clear;
		logic mul_en;
		logic acc_en;
		tap_t tap;
	} mac_ctrl_t;

	function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(DATA_MAX);
		lo = ACC_W'(DATA_MIN);
		if (v > hi) begin
			sat_acc = DATA_MAX;
		end else if (v < lo) begin
			sat_acc = DATA_MIN;
		end else begin
			sat_acc = DATA_W'(v);
		end
	endfunction

endpackage

@@ rtl/wffo_mac.sv @@
// ----------------------------------------------------------------------------
// Weighted force filter multiply-accumulate unit
// One shared multiplier stepped over the four filter taps, then rounding.
// ----------------------------------------------------------------------------
module wffo_mac import wffo_pkg::*; (
	input  logic                     clk,
	input  mac_ctrl_t                ctrl,
	input  logic signed [DATA_W-1:0] x,
	input  logic signed [DATA_W-1:0] h1,
	input  logic signed [DATA_W-1:0] h2,
	input  logic signed [DATA_W-1:0] h3,
	output logic signed [DATA_W-1:0] y
);

	logic signed [DATA_W-1:0] opnd;
	logic signed [COEF_W-1:0] coef;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  rounded;

	always_comb begin
		unique case (ctrl.tap)
			TAP_X: begin
				opnd = x;
				coef = COEF_HALF;
			end
			TAP_Y1: begin
				opnd = h1;
				coef = COEF_FIFTH;
			end
			TAP_Y2: begin
				opnd = h2;
				coef = COEF_FIFTH;
			end
			TAP_Y3: begin
				opnd = h3;
				coef = COEF_TENTH;
			end
		endcase
	end

	// The product is registered and added to the accumulator in the next cycle.
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= opnd * coef;
		end
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
	end

	// Halves round toward plus infinity.
	assign rounded = (acc_q + ROUND_BIAS) >>> ROUND_SHIFT;
	assign y = sat_acc(rounded);

endmodule

@@ rtl/wffo_ring.sv @@
// ----------------------------------------------------------------------------
// Weighted force filter history ring
// Filtered value memory with a fill count, and a walk that sums all entries.
// ----------------------------------------------------------------------------
module wffo_ring import wffo_pkg::*; #(
	parameter  int DEPTH = 16,
	localparam int SUM_W = DATA_W + $clog2(DEPTH) + 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic signed [DATA_W-1:0] wr_data,
	input  logic                     sum_start,
	output logic signed [SUM_W-1:0]  sum,
	output logic                     sum_done
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL     = CW'(DEPTH);

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic [AW-1:0]            wp_q;
	logic [CW-1:0]            fill_q;
	logic                     walking_q;
	logic [AW-1:0]            rd_idx_q;
	logic signed [DATA_W-1:0] rd_data_s1;
	logic                     rd_valid_s1;
	logic                     rd_last_s1;
	logic                     done_q;
	logic signed [SUM_W-1:0]  sum_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wp_q] <= wr_data;
		end
		rd_data_s1 <= mem[rd_idx_q];
	end

	// Entries at or above the fill count were never written and count as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			fill_q      <= '0;
			walking_q   <= 1'b0;
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (wr_en) begin
				wp_q <= (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
				if (fill_q != FULL) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			rd_valid_s1 <= walking_q && (CW'(rd_idx_q) < fill_q);
			rd_last_s1  <= walking_q && (rd_idx_q == LAST_IDX);
			done_q      <= rd_last_s1;
			if (sum_start) begin
				walking_q <= 1'b1;
				rd_idx_q  <= '0;
			end else if (walking_q) begin
				if (rd_idx_q == LAST_IDX) begin
					walking_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sum_start) begin
			sum_q <= '0;
		end else if (rd_valid_s1) begin
			sum_q <= sum_q + SUM_W'(rd_data_s1);
		end
	end

	assign sum      = sum_q;
	assign sum_done = done_q;

endmodule

@@ rtl/wffo_div.sv @@
// ----------------------------------------------------------------------------
// Weighted force filter mean divider
// Rounded ring mean, formed by a multiply with the reciprocal of the depth.
// ----------------------------------------------------------------------------
module wffo_div import wffo_pkg::*; #(
	parameter  int DEPTH = 16,
	localparam int SUM_W = DATA_W + $clog2(DEPTH) + 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [SUM_W-1:0]  sum,
	output logic signed [DATA_W-1:0] quo,
	output logic                     done
);

	localparam int LOG_W  = $clog2(DEPTH);
	localparam int SHIFT  = SUM_W + LOG_W;
	localparam int CH_W   = 16;
	localparam int NCH    = (SUM_W + CH_W) / CH_W;
	localparam int RCP_W  = NCH * CH_W;
	localparam int PR_W   = SUM_W + CH_W;
	localparam int PACC_W = SUM_W + RCP_W;
	localparam int CNT_W  = $clog2(NCH + 1);
	localparam logic [SUM_W-1:0] HALF       = SUM_W'(DEPTH / 2);
	localparam logic [SUM_W-1:0] BIAS       = SUM_W'(DEPTH - 1);
	localparam logic [63:0]      RECIP_FULL =
		((64'd1 << SHIFT) + 64'(DEPTH - 1)) / 64'(DEPTH);
	localparam logic [RCP_W-1:0] RECIP      = RCP_W'(RECIP_FULL);
	localparam logic [CNT_W-1:0] STEPS      = CNT_W'(NCH);

	logic [SUM_W-1:0]  num;
	logic              neg;
	logic [SUM_W-1:0]  mag;
	logic [CH_W-1:0]   digit;
	logic [PR_W-1:0]   prod;
	logic [DATA_W-1:0] mag_quo;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  mag_q;
	logic [RCP_W-1:0]  rcp_q;
	logic [PACC_W-1:0] acc_q;
	logic              neg_q;
	logic              done_q;

	// A negative numerator is divided as a magnitude biased up, which turns
	// truncation into floor.
	assign num = sum + HALF;
	assign neg = num[SUM_W-1];
	assign mag = neg ? (~num + SUM_W'(1)) + BIAS : num;

	// The magnitude times the rounded-up reciprocal, shifted down, is the exact
	// quotient for every magnitude that fits in SUM_W bits. The reciprocal is
	// taken 16 bits a cycle, from the top.
	assign digit   = rcp_q[RCP_W-1 -: CH_W];
	assign prod    = PR_W'(mag_q) * PR_W'(digit);
	assign mag_quo = acc_q[SHIFT +: DATA_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
			rcp_q <= RECIP;
			acc_q <= '0;
			neg_q <= neg;
		end else if (busy_q) begin
			acc_q <= (acc_q << CH_W) + PACC_W'(prod);
			rcp_q <= rcp_q << CH_W;
		end
	end

	assign quo  = neg_q ? -mag_quo : mag_quo;
	assign done = done_q;

endmodule

@@ rtl/weighted_force_filter_offset.sv @@
// ----------------------------------------------------------------------------
// Weighted force filter with offset capture
// Three-tap recursive force filter with a mean offset capture at a set position.
// ----------------------------------------------------------------------------
// Raw Q16.16 force samples enter on s_axis, one per request, and each gives
// one m_axis result: the filtered value minus the current offset, saturated,
// tuser set on the sample that latched a new offset. The user writes the cfg
// channel capture position only while idle; the block does not enforce it.
//
// A sample is accepted only after the one before it has loaded its result:
// the shared multiplier runs over the four taps in ST_MAC, ST_FIN stores
// the value and ST_OUT loads the output register. On the capture sample
// the ring is walked one entry a cycle and the mean comes from a 3-step
// reciprocal multiply.
//
// Reset clears the history, the sample count and the offset, and sets the
// capture position to 1000. A finished result waits in the output register
// while the next sample is accepted and filtered; a stalled receiver holds
// the block only when that next result is ready to be loaded.
// ----------------------------------------------------------------------------
module weighted_force_filter_offset import wffo_pkg::*; #(
	parameter int RING_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] raw_force
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] filtered_force
	output logic [0:0]        m_axis_tuser,   // [0] offset_latched
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int SUM_W = DATA_W + $clog2(RING_DEPTH) + 1;

	state_t state_q;
	state_t state_d;

	logic [2:0]               k_q;
	logic signed [DATA_W-1:0] x_q;
	logic signed [DATA_W-1:0] h1_q;
	logic signed [DATA_W-1:0] h2_q;
	logic signed [DATA_W-1:0] h3_q;
	logic [CFG_W-1:0]         seen_q;
	logic [CFG_W-1:0]         cap_q;
	logic signed [DATA_W-1:0] offset_q;
	logic signed [DATA_W-1:0] diff_q;
	logic                     latch_q;
	logic                     out_valid_q;
	logic [DATA_W-1:0]        out_data_q;
	logic                     out_user_q;

	mac_ctrl_t                mac_ctrl;
	logic signed [DATA_W-1:0] y;
	logic signed [DATA_W:0]   diff_w;
	logic                     hit;
	logic                     ring_wr;
	logic                     sum_start;
	logic signed [SUM_W-1:0]  ring_sum;
	logic                     sum_done;
	logic signed [DATA_W-1:0] mean;
	logic                     div_done;
	logic                     in_take;
	logic                     out_load;
	logic                     mac_last;

	assign in_take  = s_axis_tvalid && s_axis_tready;
	assign mac_last = (k_q == 3'd4);
	assign hit      = (seen_q == cap_q);
	assign diff_w   = (DATA_W + 1)'(y) - (DATA_W + 1)'(offset_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_axis_tvalid) state_d = ST_MAC;
			ST_MAC:  if (mac_last) state_d = ST_FIN;
			ST_FIN:  state_d = hit ? ST_SUM : ST_OUT;
			ST_SUM:  if (sum_done) state_d = ST_DIV;
			ST_DIV:  if (div_done) state_d = ST_OUT;
			ST_OUT:  if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		mac_ctrl      = '{clear: 1'b0, mul_en: 1'b0, acc_en: 1'b0, tap: TAP_X};
		ring_wr       = 1'b0;
		sum_start     = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_MAC: begin
				mac_ctrl.clear  = (k_q == 3'd0);
				mac_ctrl.mul_en = !mac_last;
				mac_ctrl.acc_en = (k_q != 3'd0);
				mac_ctrl.tap    = tap_t'(k_q[1:0]);
			end
			ST_FIN: begin
				ring_wr   = 1'b1;
				sum_start = hit;
			end
			ST_SUM: ;
			ST_DIV: ;
			ST_OUT: out_load = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			h1_q        <= '0;
			h2_q        <= '0;
			h3_q        <= '0;
			seen_q      <= '0;
			cap_q       <= CAPTURE_RESET;
			offset_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_take) begin
				k_q <= '0;
			end else if (state_q == ST_MAC) begin
				k_q <= k_q + 1'b1;
			end
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (state_q == ST_FIN) begin
				h3_q <= h2_q;
				h2_q <= h1_q;
				h1_q <= y;
				if (seen_q != SEEN_MAX) begin
					seen_q <= seen_q + 1'b1;
				end
			end
			if (div_done) begin
				offset_q <= mean;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The difference uses the offset in force before any new capture.
	always_ff @(posedge clk) begin
		if (in_take) begin
			x_q <= s_axis_tdata;
		end
		if (state_q == ST_FIN) begin
			diff_q  <= sat_acc(ACC_W'(diff_w));
			latch_q <= hit;
		end
		if (out_load) begin
			out_data_q <= diff_q;
			out_user_q <= latch_q;
		end
	end

	wffo_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.x    (x_q),
		.h1   (h1_q),
		.h2   (h2_q),
		.h3   (h3_q),
		.y    (y)
	);

	wffo_ring #(.DEPTH(RING_DEPTH)) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (ring_wr),
		.wr_data   (y),
		.sum_start (sum_start),
		.sum       (ring_sum),
		.sum_done  (sum_done)
	);

	wffo_div #(.DEPTH(RING_DEPTH)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sum_done),
		.sum    (ring_sum),
		.quo    (mean),
		.done   (div_done)
	);

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

@@ rtl/wffo_checker.sv @@
// ----------------------------------------------------------------------------
// Weighted force filter port checker
// Port-level checks on the sample and result channels, bound to the top.
// ----------------------------------------------------------------------------
`include "weighted_force_filter_offset_defines.svh"

module wffo_checker import wffo_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic [DATA_W-1:0] s_axis_tdata,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [DATA_W-1:0] m_axis_tdata,
	input logic [0:0]        m_axis_tuser
);

	logic in_take;
	logic out_stall;

	assign in_take   = s_axis_tvalid && s_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	`WFFO_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
	`WFFO_ASSERT_NEXT(a_busy_after_take, in_take, !s_axis_tready, "ready right after a sample request")
	`WFFO_ASSERT_SAME(a_busy_in_filter, in_take, ##6 !s_axis_tready, "ready before the filter finished")
	`WFFO_ASSERT_SAME(a_load_frees_input, $rose(m_axis_tvalid), s_axis_tready, "result loaded while input held")

	// The sample payload itself is not checked; it is only watched for X.
	`WFFO_ASSERT_SAME(a_take_known, in_take, !$isunknown(s_axis_tdata), "unknown sample data")

endmodule

bind weighted_force_filter_offset wffo_checker u_wffo_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

@@ test/weighted_force_filter_offset_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weighted force filter testbench
// Drives force samples and capture positions into the filter, checks each
// result against a plan value or a cycle-free model of filter, ring and offset.
// ----------------------------------------------------------------------------
module weighted_force_filter_offset_tb;
	import wffo_pkg::*;

	localparam int RING_DEPTH     = 16;
	localparam int PTR_W          = $clog2(RING_DEPTH);
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 120;
	localparam int PHASE_COUNT    = 6;
	localparam int PHASE_SAMPLES  = 283;
	localparam int PLAN_ROWS      = 20;
	localparam int HOLD_AFTER     = 400;
	localparam int HOLD_CYCLES    = 300;

	localparam logic signed [63:0] Q15_HALF  = 64'sd16384;
	localparam logic signed [63:0] Q15_FIFTH = 64'sd6554;
	localparam logic signed [63:0] Q15_TENTH = 64'sd3277;
	localparam logic signed [63:0] Q15_ROUND = 64'sd16384;
	localparam logic signed [31:0] Q_MAX     = 32'h7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN     = 32'h8000_0000;
	localparam logic [CFG_W-1:0]   POS_MAX   = '1;

	typedef struct packed {
		logic signed [31:0] force_q;
		logic               latch;
	} force_result_t;

	typedef enum logic {
		ROW_SAMPLE,
		ROW_CAPTURE
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] value;
		logic        known;
		logic [31:0] exp_force;
		logic        exp_latch;
	} plan_row_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata  = '0;   // [31:0] raw_force
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;         // [31:0] filtered_force
	logic [0:0]        m_axis_tuser;         // [0] offset_latched
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_data      = '0;

	// Model state.
	logic signed [31:0] hist_ring [RING_DEPTH];
	logic [PTR_W-1:0]   hist_wp;
	logic [CFG_W-1:0]   seen_count;
	logic [CFG_W-1:0]   capture_pos;
	logic signed [31:0] held_offset;

	force_result_t pending_results [$];
	int            mismatch_count = 0;
	int            tx_idle_pct    = 0;
	int            rx_idle_pct    = 0;
	int            rx_count       = 0;
	int            hold_left      = 0;
	bit            hold_done      = 1'b0;
	int            stall_cycles   = 0;

	weighted_force_filter_offset #(
		.RING_DEPTH(RING_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return Q_MAX;
		end else if (v < -64'sd2147483648) begin
			return Q_MIN;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [63:0] widen(input logic signed [31:0] v);
		return v;
	endfunction

	function automatic logic signed [63:0] history_tap(input int k);
		return widen(hist_ring[PTR_W'(hist_wp - PTR_W'(k))]);
	endfunction

	function automatic void reset_model();
		foreach (hist_ring[i]) begin
			hist_ring[i] = '0;
		end
		hist_wp     = '0;
		seen_count  = '0;
		capture_pos = CFG_W'(1000);
		held_offset = '0;
	endfunction

	function automatic force_result_t filter_sample(input logic signed [31:0] x);
		logic signed [63:0] acc;
		logic signed [63:0] total;
		logic signed [31:0] y;
		force_result_t      r;
		acc = widen(x) * Q15_HALF + history_tap(1) * Q15_FIFTH
			+ history_tap(2) * Q15_FIFTH + history_tap(3) * Q15_TENTH;
		// An arithmetic shift is a floor division, so halves round upward.
		y = clamp32((acc + Q15_ROUND) >>> 15);
		hist_ring[hist_wp] = y;
		hist_wp = hist_wp + 1'b1;
		r.force_q = clamp32(widen(y) - widen(held_offset));
		r.latch   = 1'b0;
		if (seen_count == capture_pos) begin
			total = '0;
			for (int i = 0; i < RING_DEPTH; i++) begin
				total += widen(hist_ring[i]);
			end
			held_offset = clamp32((total + RING_DEPTH / 2) >>> PTR_W);
			r.latch = 1'b1;
		end
		if (seen_count != POS_MAX) begin
			seen_count = seen_count + 1'b1;
		end
		return r;
	endfunction

	function automatic logic [31:0] random_sample(input int style);
		case (style)
			5, 6: return 32'(int'($urandom_range(0, 262143)) - 131072);
			7: return Q_MAX;
			8: return Q_MIN;
			9: begin
				case ($urandom_range(4))
					0: return 32'h0000_0000;
					1: return 32'h0000_0001;
					2: return 32'hFFFF_FFFF;
					3: return 32'h0000_8000;
					default: return 32'hFFFF_8000;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic push_sample(input logic [31:0] x, input logic known,
			input force_result_t typed);
		force_result_t r;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= x;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		r = filter_sample(x);
		pending_results.push_back(known ? typed : r);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_capture(input logic [CFG_W-1:0] pos);
		cfg_valid <= 1'b1;
		cfg_data  <= pos;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid   <= 1'b0;
		capture_pos = pos;
	endtask

	// Receiver: random stalls, plus one long hold-off that fills the block.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			rx_count++;
		end
		if (!hold_done && rx_count >= HOLD_AFTER) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		force_result_t got;
		force_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.force_q = m_axis_tdata;
			got.latch   = m_axis_tuser[0];
			if (pending_results.size() == 0) begin
				if (mismatch_count < 10) begin
					$display("unexpected result: force %h latch %b", got.force_q, got.latch);
				end
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					if (mismatch_count < 10) begin
						$display("mismatch: expected force %h latch %b, got force %h latch %b",
							want.force_q, want.latch, got.force_q, got.latch);
					end
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		plan_row_t        plan [0:PLAN_ROWS-1];
		force_result_t    typed;
		int               chunk_left;
		int               style;
		logic [CFG_W-1:0] pos;

		reset_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 23;
		rx_idle_pct = 73;

		// Opening rows: a sample with the cleared history, then a latch on the
		// very next sample, saturation with repeated extremes, a second latch
		// that replaces the first, a position already passed, and the largest
		// position, which this run never reaches.
		plan = '{
			'{ROW_SAMPLE,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
			'{ROW_CAPTURE, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
			'{ROW_SAMPLE,  32'h7FFF_FFFF, 1'b1, 32'h4000_0000, 1'b1},
			'{ROW_SAMPLE,  32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
			'{ROW_SAMPLE,  32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
			'{ROW_SAMPLE,  32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
			'{ROW_SAMPLE,  32'h8000_0000, 1'b0, 32'h0, 1'b0},
			'{ROW_SAMPLE,  32'h8000_0000, 1'b0, 32'h0, 1'b0},
			'{ROW_SAMPLE,  32'h8000_0000, 1'b0, 32'h0, 1'b0},
			'{ROW_SAMPLE,  32'h8000_0000, 1'b0, 32'h0, 1'b0},
			'{ROW_CAPTURE, 32'h0000_000A, 1'b0, 32'h0, 1'b0},
			'{ROW_SAMPLE,  32'h0000_0001, 1'b0, 32'h0, 1'b0},
			'{ROW_SAMPLE,  32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
			'{ROW_CAPTURE, 32'h0000_0003, 1'b0, 32'h0, 1'b0},
			'{ROW_SAMPLE,  32'h8000_0000, 1'b0, 32'h0, 1'b0},
			'{ROW_SAMPLE,  32'h8000_0000, 1'b0, 32'h0, 1'b0},
			'{ROW_SAMPLE,  32'h0000_8000, 1'b0, 32'h0, 1'b0},
			'{ROW_SAMPLE,  32'hFFFF_8000, 1'b0, 32'h0, 1'b0},
			'{ROW_CAPTURE, 32'h000F_FFFF, 1'b0, 32'h0, 1'b0},
			'{ROW_SAMPLE,  32'h0000_0000, 1'b0, 32'h0, 1'b0}
		};

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CAPTURE) begin
				drain();
				write_capture(plan[i].value[CFG_W-1:0]);
			end else begin
				typed.force_q = plan[i].exp_force;
				typed.latch   = plan[i].exp_latch;
				push_sample(plan[i].value, plan[i].known, typed);
			end
		end

		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p / 2)
				0: begin
					tx_idle_pct = 23;
					rx_idle_pct = 73;
				end
				1: begin
					tx_idle_pct = 73;
					rx_idle_pct = 23;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			drain();
			// Mostly positions a little ahead of the count, so that a latch
			// lands early or mid-phase; now and then one far away.
			case (p % 3)
				0: pos = seen_count + CFG_W'($urandom_range(1, 80));
				1: pos = CFG_W'($urandom);
				default: pos = seen_count + CFG_W'($urandom_range(100, 250));
			endcase
			write_capture(pos);
			chunk_left = 0;
			style = 0;
			for (int n = 0; n < PHASE_SAMPLES; n++) begin
				if (chunk_left == 0) begin
					style = $urandom_range(9);
					chunk_left = $urandom_range(8, 40);
				end
				chunk_left--;
				push_sample(random_sample(style), 1'b0, '0);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/wffo_pkg.sv
rtl/wffo_mac.sv
rtl/wffo_ring.sv
rtl/wffo_div.sv
rtl/weighted_force_filter_offset.sv
rtl/wffo_checker.sv
test/weighted_force_filter_offset_tb.sv
